@@ design/sst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg
// types and constants shared by the sample statistics tracker modules
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int LANES      = 4;
  localparam int CODE_W     = 16;
  localparam int CNT_W      = 32;
  localparam int TIME_W     = 64;
  localparam int IN_DATA_W  = 232;
  localparam int OUT_DATA_W = 416;

  // request kinds carried on tuser
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  typedef struct packed {
    logic                    opcode;
    logic [TIME_W-1:0]       capture_time;
    logic [CNT_W-1:0]        read_duration;
    logic [CNT_W-1:0]        write_duration;
    logic [CNT_W-1:0]        missed_tick_count;
    logic                    write_was_dropped;
    logic                    doorbell_was_failed;
    logic [LANES*CODE_W-1:0] sensor_codes;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] samples_seen;
    logic [CNT_W-1:0] overruns_total;
    logic [CNT_W-1:0] read_duration_peak;
    logic [CNT_W-1:0] write_duration_peak;
    logic [CNT_W-1:0] drops_total;
    logic [CNT_W-1:0] retries_total;
    logic [CNT_W-1:0] interval_low;
    logic [CNT_W-1:0] interval_high;
    logic [CNT_W-1:0] timeouts_total;
  } stats_t;

  // per-lane update control from the counter block
  typedef struct packed {
    logic update;
    logic first;
  } lane_ctl_t;

endpackage

@@ design/sst_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_lane
// running minimum and maximum of one sensor code
// ----------------------------------------------------------------------------
module sst_lane (
  input  logic                            clk,
  input  logic                            rst,
  input  sst_pkg::lane_ctl_t              ctl,
  input  logic [sst_pkg::CODE_W-1:0]      code,
  output logic [sst_pkg::CODE_W-1:0]      code_low_next,
  output logic [sst_pkg::CODE_W-1:0]      code_high_next
);
  import sst_pkg::*;

  logic [CODE_W-1:0] code_low;
  logic [CODE_W-1:0] code_high;

  always_comb begin
    code_low_next  = code_low;
    code_high_next = code_high;
    if (ctl.update) begin
      if (ctl.first) begin
        code_low_next  = code;
        code_high_next = code;
      end else begin
        if (code < code_low)  code_low_next  = code;
        if (code > code_high) code_high_next = code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_low  <= '0;
      code_high <= '0;
    end else begin
      code_low  <= code_low_next;
      code_high <= code_high_next;
    end
  end

endmodule

@@ design/sst_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_core
// counters, duration peaks and capture interval range
// ----------------------------------------------------------------------------
module sst_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  sst_pkg::item_t       item,
  output sst_pkg::stats_t      stats_next,
  output sst_pkg::lane_ctl_t   lane_ctl
);
  import sst_pkg::*;

  stats_t            stats;
  logic [TIME_W-1:0] prev_capture;
  logic [TIME_W-1:0] prev_capture_next;
  logic [CNT_W-1:0]  gap;

  // interval wraps at 32 bits, so only the low word matters
  assign gap = item.capture_time[CNT_W-1:0] - prev_capture[CNT_W-1:0];

  always_comb begin
    stats_next        = stats;
    prev_capture_next = prev_capture;
    lane_ctl.update   = 1'b0;
    lane_ctl.first    = (stats.samples_seen == '0);
    if (step) begin
      unique case (item.opcode)
        OP_TIMEOUT: begin
          stats_next.timeouts_total = stats.timeouts_total + CNT_W'(1);
        end
        OP_SAMPLE: begin
          lane_ctl.update           = 1'b1;
          stats_next.samples_seen   = stats.samples_seen + CNT_W'(1);
          stats_next.overruns_total = stats.overruns_total + item.missed_tick_count;
          if (item.read_duration > stats.read_duration_peak)
            stats_next.read_duration_peak = item.read_duration;
          if (item.write_duration > stats.write_duration_peak)
            stats_next.write_duration_peak = item.write_duration;
          if (item.write_was_dropped)
            stats_next.drops_total = stats.drops_total + CNT_W'(1);
          if (item.doorbell_was_failed)
            stats_next.retries_total = stats.retries_total + CNT_W'(1);
          // no interval while the previous capture time is zero
          if (prev_capture != '0) begin
            if (gap < stats.interval_low)  stats_next.interval_low  = gap;
            if (gap > stats.interval_high) stats_next.interval_high = gap;
          end
          prev_capture_next = item.capture_time;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // everything zero except the minimum interval, which starts at all ones
      stats        <= {{6*CNT_W{1'b0}}, {CNT_W{1'b1}}, {2*CNT_W{1'b0}}};
      prev_capture <= '0;
    end else begin
      stats        <= stats_next;
      prev_capture <= prev_capture_next;
    end
  end

endmodule

@@ design/sample_statistics_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_statistics_tracker
// running statistics over a stream of sensor sample requests
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one request per beat; tuser is the kind (sample or timer
//   timeout), tdata the sample fields. m_axis returns one beat per request
//   with the full statistics snapshot taken right after that request.
// datapath: one input register, then the update logic feeding the result
//   register; a stall on m_axis holds the request in the input register.
// throughput: one request per cycle while m_axis_tready is not held low;
//   the update loop through the statistics registers does not limit it.
// stall: while a result waits on m_axis_tready, the input register still
//   takes one more request; after that s_axis_tready drops until the result
//   drains. nothing is lost or repeated.
// reset: rst (sync, active high) empties both stages, clears all counters,
//   peaks and sensor lanes to zero and sets the minimum interval to all ones.
// SENSOR_COUNT sets how many sensor lanes are tracked; untracked lanes read
//   as zero in the packed code fields.
// ----------------------------------------------------------------------------
module sample_statistics_tracker #(
  parameter int SENSOR_COUNT = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // capture_time, read_duration, write_duration, missed_tick_count,
  // write_was_dropped, doorbell_was_failed, sensor_codes, zero pad
  input  logic [sst_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // opcode
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // samples_seen, overruns_total, read_duration_peak, write_duration_peak,
  // drops_total, retries_total, interval_low, interval_high,
  // timeouts_total, sensor_low_codes, sensor_high_codes
  output logic [sst_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import sst_pkg::*;

  // input stage
  logic      in_valid;
  item_t     in_item;
  logic      out_ready;
  logic      step;

  // update logic
  stats_t                  stats_next;
  lane_ctl_t               lane_ctl;
  logic [LANES*CODE_W-1:0] low_codes_next;
  logic [LANES*CODE_W-1:0] high_codes_next;

  // result register
  logic      out_valid;
  stats_t    out_stats;
  logic [LANES*CODE_W-1:0] out_low_codes;
  logic [LANES*CODE_W-1:0] out_high_codes;

  assign out_ready     = !out_valid || m_axis_tready;
  assign step          = in_valid && out_ready;
  assign s_axis_tready = !in_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  // unpack the request into the item register
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.opcode              <= s_axis_tuser;
      in_item.capture_time        <= s_axis_tdata[63:0];
      in_item.read_duration       <= s_axis_tdata[95:64];
      in_item.write_duration      <= s_axis_tdata[127:96];
      in_item.missed_tick_count   <= s_axis_tdata[159:128];
      in_item.write_was_dropped   <= s_axis_tdata[160];
      in_item.doorbell_was_failed <= s_axis_tdata[161];
      in_item.sensor_codes        <= s_axis_tdata[225:162];
    end
  end

  sst_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .item       (in_item),
    .stats_next (stats_next),
    .lane_ctl   (lane_ctl)
  );

  // one min/max cell per tracked sensor; the rest stay zero
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i < SENSOR_COUNT) begin : g_on
      sst_lane u_lane (
        .clk            (clk),
        .rst            (rst),
        .ctl            (lane_ctl),
        .code           (in_item.sensor_codes[i*CODE_W +: CODE_W]),
        .code_low_next  (low_codes_next[i*CODE_W +: CODE_W]),
        .code_high_next (high_codes_next[i*CODE_W +: CODE_W])
      );
    end else begin : g_off
      assign low_codes_next[i*CODE_W +: CODE_W]  = '0;
      assign high_codes_next[i*CODE_W +: CODE_W] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= in_valid;
    end
  end

  // snapshot of the statistics after this request
  always_ff @(posedge clk) begin
    if (step) begin
      out_stats      <= stats_next;
      out_low_codes  <= low_codes_next;
      out_high_codes <= high_codes_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_high_codes, out_low_codes,
                          out_stats.timeouts_total, out_stats.interval_high,
                          out_stats.interval_low, out_stats.retries_total,
                          out_stats.drops_total, out_stats.write_duration_peak,
                          out_stats.read_duration_peak, out_stats.overruns_total,
                          out_stats.samples_seen};

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// regression for sample_statistics_tracker: directed corner requests, then
// random sample and timeout requests with random gaps and stalls on both
// streams; every snapshot is checked field by field against a local model
// ----------------------------------------------------------------------------
module tb;
  import sst_pkg::*;

  localparam int SENSORS     = 4;
  localparam int RANDOM_REQS = 450;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PAD_W       = IN_DATA_W - 226;

  // result beat, last field in the top bits
  typedef struct packed {
    logic [63:0] sensor_high_codes;
    logic [63:0] sensor_low_codes;
    logic [31:0] timeouts_total;
    logic [31:0] interval_high;
    logic [31:0] interval_low;
    logic [31:0] retries_total;
    logic [31:0] drops_total;
    logic [31:0] write_duration_peak;
    logic [31:0] read_duration_peak;
    logic [31:0] overruns_total;
    logic [31:0] samples_seen;
  } snapshot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = OP_SAMPLE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  sample_statistics_tracker #(
    .SENSOR_COUNT(SENSORS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // statistics model, advanced once per accepted request
  // ---------------------------------------------------------------------------
  logic [31:0]              tally_samples  = '0;
  logic [31:0]              tally_overruns = '0;
  logic [31:0]              peak_read      = '0;
  logic [31:0]              peak_write     = '0;
  logic [31:0]              tally_drops    = '0;
  logic [31:0]              tally_retries  = '0;
  logic [31:0]              gap_min        = '1;
  logic [31:0]              gap_max        = '0;
  logic [31:0]              tally_timeouts = '0;
  logic [63:0]              last_capture   = '0;
  logic [LANES-1:0][15:0]   code_min       = '0;
  logic [LANES-1:0][15:0]   code_max       = '0;

  function automatic snapshot_t fold_request(input item_t r);
    snapshot_t   s;
    logic [31:0] gap;
    logic [15:0] code;
    if (r.opcode == OP_TIMEOUT) begin
      // sample fields are don't-care here, capture history untouched
      tally_timeouts = tally_timeouts + 32'd1;
    end else begin
      tally_samples  = tally_samples + 32'd1;
      tally_overruns = tally_overruns + r.missed_tick_count;
      if (r.read_duration > peak_read) peak_read = r.read_duration;
      if (r.write_duration > peak_write) peak_write = r.write_duration;
      if (r.write_was_dropped) tally_drops = tally_drops + 32'd1;
      if (r.doorbell_was_failed) tally_retries = tally_retries + 32'd1;
      // no interval while the stored capture time is zero
      if (last_capture != 64'd0) begin
        gap = r.capture_time[31:0] - last_capture[31:0];
        if (gap < gap_min) gap_min = gap;
        if (gap > gap_max) gap_max = gap;
      end
      for (int lane = 0; lane < LANES; lane++) begin
        if (lane < SENSORS) begin
          code = r.sensor_codes[lane*CODE_W +: CODE_W];
          // a count of one (first sample or a wrap) reloads both bounds
          if (tally_samples == 32'd1) begin
            code_min[lane] = code;
            code_max[lane] = code;
          end else begin
            if (code < code_min[lane]) code_min[lane] = code;
            if (code > code_max[lane]) code_max[lane] = code;
          end
        end
      end
      last_capture = r.capture_time;
    end
    s.samples_seen        = tally_samples;
    s.overruns_total      = tally_overruns;
    s.read_duration_peak  = peak_read;
    s.write_duration_peak = peak_write;
    s.drops_total         = tally_drops;
    s.retries_total       = tally_retries;
    s.interval_low        = gap_min;
    s.interval_high       = gap_max;
    s.timeouts_total      = tally_timeouts;
    s.sensor_low_codes    = code_min;
    s.sensor_high_codes   = code_max;
    return s;
  endfunction

  function automatic item_t make_req(input logic op, input logic [63:0] t,
                                     input logic [31:0] rd, input logic [31:0] wr,
                                     input logic [31:0] miss, input logic drop,
                                     input logic bell, input logic [63:0] codes);
    item_t r;
    r.opcode              = op;
    r.capture_time        = t;
    r.read_duration       = rd;
    r.write_duration      = wr;
    r.missed_tick_count   = miss;
    r.write_was_dropped   = drop;
    r.doorbell_was_failed = bell;
    r.sensor_codes        = codes;
    return r;
  endfunction

  // tdata layout from bit 0 up: capture_time, read_duration, write_duration,
  // missed_tick_count, write_was_dropped, doorbell_was_failed, sensor_codes
  function automatic logic [IN_DATA_W-1:0] pack_request(input item_t r);
    return {{PAD_W{1'b0}}, r.sensor_codes, r.doorbell_was_failed, r.write_was_dropped,
            r.missed_tick_count, r.write_duration, r.read_duration, r.capture_time};
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_span();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------
  item_t     pending_reqs[$];
  item_t     on_wire;
  item_t     next_req;
  snapshot_t expected_stats[$];
  int        reqs_sent   = 0;
  int        send_gap    = 0;
  int        send_calm   = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_stats.push_back(fold_request(on_wire));
        reqs_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          next_req = pending_reqs.pop_front();
          on_wire       <= next_req;
          s_axis_tdata  <= pack_request(next_req);
          s_axis_tuser  <= next_req.opcode;
          s_axis_tvalid <= 1'b1;
          if (send_calm > 0) begin
            send_calm--;
            send_gap = 0;
          end else begin
            send_gap = idle_span();
            if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(15, 40);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and checker
  // ---------------------------------------------------------------------------
  int        results_checked = 0;
  int        mismatch_count  = 0;
  int        hold_left       = 0;
  int        recv_calm       = 0;
  snapshot_t got_stats;
  snapshot_t want_stats;

  task automatic check_field(input string fname, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch in result %0d, %s: expected %h, got %h",
                 results_checked, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_stats = m_axis_tdata;
      if (expected_stats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result with nothing pending: %h", m_axis_tdata);
      end else begin
        want_stats = expected_stats.pop_front();
        check_field("samples_seen", got_stats.samples_seen, want_stats.samples_seen);
        check_field("overruns_total", got_stats.overruns_total, want_stats.overruns_total);
        check_field("read_duration_peak", got_stats.read_duration_peak,
                    want_stats.read_duration_peak);
        check_field("write_duration_peak", got_stats.write_duration_peak,
                    want_stats.write_duration_peak);
        check_field("drops_total", got_stats.drops_total, want_stats.drops_total);
        check_field("retries_total", got_stats.retries_total, want_stats.retries_total);
        check_field("interval_low", got_stats.interval_low, want_stats.interval_low);
        check_field("interval_high", got_stats.interval_high, want_stats.interval_high);
        check_field("timeouts_total", got_stats.timeouts_total, want_stats.timeouts_total);
        check_field("sensor_low_codes", got_stats.sensor_low_codes,
                    want_stats.sensor_low_codes);
        check_field("sensor_high_codes", got_stats.sensor_high_codes,
                    want_stats.sensor_high_codes);
      end
      results_checked++;
    end
    // back-pressure: random stalls with occasional long stall-free stretches
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (recv_calm > 0) recv_calm--;
      else begin
        hold_left = ($urandom_range(0, 3) == 0) ? idle_span() : 0;
        if ($urandom_range(0, 199) == 0) recv_calm = $urandom_range(40, 120);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, expected_stats.size());
      $display("sample_statistics_tracker regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  int          total_reqs;
  int          n_samples;
  int          n_timeouts;
  logic [63:0] now_us;
  logic [63:0] codes;
  logic [31:0] rd;
  logic [31:0] wr;
  logic [31:0] miss;
  int          roll;

  initial begin
    // timeout before any sample, all other statistics still at reset values
    pending_reqs.push_back(make_req(OP_TIMEOUT, rand64(), $urandom, $urandom, $urandom,
                                    1'b1, 1'b1, rand64()));
    // first sample at time zero loads every lane
    pending_reqs.push_back(make_req(OP_SAMPLE, 64'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
                                    64'h0000_ffff_8000_0001));
    // stored capture time is zero, so still no interval
    pending_reqs.push_back(make_req(OP_SAMPLE, 64'd0, 32'd7, 32'd3, 32'd0, 1'b0, 1'b0,
                                    64'hffff_ffff_ffff_ffff));
    pending_reqs.push_back(make_req(OP_SAMPLE, 64'd1000, 32'hffff_ffff, 32'd1,
                                    32'hffff_ffff, 1'b1, 1'b1, 64'd0));
    // first interval, overrun total wraps to zero
    pending_reqs.push_back(make_req(OP_SAMPLE, 64'd1500, 32'd10, 32'd2, 32'd1, 1'b0, 1'b1,
                                    64'h1234_5678_9abc_def0));
    // timeout in the middle keeps the capture history
    pending_reqs.push_back(make_req(OP_TIMEOUT, 64'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
                                    64'd0));
    // zero interval
    pending_reqs.push_back(make_req(OP_SAMPLE, 64'd1500, 32'd5, 32'd5, 32'd0, 1'b1, 1'b0,
                                    64'h0001_0001_0001_0001));
    pending_reqs.push_back(make_req(OP_SAMPLE, 64'hffff_ffff_ffff_ffff, 32'd0, 32'd0,
                                    32'd2, 1'b0, 1'b0, 64'h8000_8000_8000_8000));
    // time going backwards wraps modulo 2^32
    pending_reqs.push_back(make_req(OP_SAMPLE, 64'd5, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
                                    64'h7fff_7fff_7fff_7fff));
    // a gap of exactly 2^32 truncates to zero
    pending_reqs.push_back(make_req(OP_SAMPLE, 64'h1_0000_0005, 32'd0, 32'd0, 32'd0, 1'b0,
                                    1'b0, 64'h0000_0000_0000_0000));
    // largest possible interval
    pending_reqs.push_back(make_req(OP_SAMPLE, 64'h2_0000_0004, 32'd0, 32'hffff_ffff,
                                    32'd0, 1'b0, 1'b0, 64'hffff_0000_ffff_0000));
    pending_reqs.push_back(make_req(OP_TIMEOUT, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff,
                                    32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1,
                                    64'hffff_ffff_ffff_ffff));
    pending_reqs.push_back(make_req(OP_SAMPLE, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff,
                                    32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1,
                                    64'hffff_ffff_ffff_ffff));
    // capture time zero is stored, so the next sample measures nothing
    pending_reqs.push_back(make_req(OP_SAMPLE, 64'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
                                    64'd0));
    pending_reqs.push_back(make_req(OP_SAMPLE, 64'd100, 32'd1, 32'd1, 32'd1, 1'b1, 1'b0,
                                    64'haaaa_aaaa_aaaa_aaaa));
    pending_reqs.push_back(make_req(OP_SAMPLE, 64'h5555_5555_5555_5555, 32'h5555_5555,
                                    32'haaaa_aaaa, 32'h5555_5555, 1'b0, 1'b1,
                                    64'h5555_5555_5555_5555));
    pending_reqs.push_back(make_req(OP_SAMPLE, 64'haaaa_aaaa_aaaa_aaaa, 32'haaaa_aaaa,
                                    32'h5555_5555, 32'haaaa_aaaa, 1'b1, 1'b1,
                                    64'haaaa_5555_aaaa_5555));

    // random part: mostly steady sample periods, some jumps, resets and noise
    now_us = 64'd10_000;
    for (int i = 0; i < RANDOM_REQS; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) now_us = now_us + $urandom_range(900, 1100);
      else if (roll < 87) now_us = now_us + $urandom_range(2000, 200000);
      else if (roll < 91) now_us = now_us - $urandom_range(1, 5000);
      else if (roll < 97) now_us = rand64();
      else now_us = 64'd0;
      rd   = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 5000) : $urandom;
      wr   = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 20000) : $urandom;
      roll = $urandom_range(0, 99);
      miss = (roll < 60) ? 32'd0 : (roll < 85) ? $urandom_range(1, 3) : $urandom;
      for (int lane = 0; lane < LANES; lane++) begin
        roll = $urandom_range(0, 9);
        codes[lane*16 +: 16] = (roll == 0) ? 16'h0000 :
                               (roll == 1) ? 16'hffff : 16'($urandom_range(0, 65535));
      end
      pending_reqs.push_back(make_req(($urandom_range(0, 99) < 15) ? OP_TIMEOUT : OP_SAMPLE,
                                      now_us, rd, wr, miss, $urandom_range(0, 9) == 0,
                                      $urandom_range(0, 9) == 0, codes));
    end

    total_reqs = pending_reqs.size();
    n_samples  = 0;
    n_timeouts = 0;
    foreach (pending_reqs[k]) begin
      if (pending_reqs[k].opcode == OP_TIMEOUT) n_timeouts++;
      else n_samples++;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (reqs_sent < total_reqs || expected_stats.size() != 0) @(posedge clk);
    // a few more cycles so a stray extra result would still be seen
    repeat (10) @(posedge clk);

    if (expected_stats.size() != 0) begin
      mismatch_count++;
      $display("%0d expected results never arrived", expected_stats.size());
    end
    $display("sent %0d requests (%0d samples, %0d timeouts) with random gaps and stalls",
             total_reqs, n_samples, n_timeouts);
    $display("checked %0d snapshots, %0d failures", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("sample_statistics_tracker regression: pass");
    end else begin
      $display("sample_statistics_tracker regression: fail");
    end
    $finish;
  end

endmodule
